/* rtl/fmr_pkg.sv */
// Shared types and constants for the framed message receiver.
// Used by every file of the block but fmr_if; depends on nothing.
package fmr_pkg;

  localparam logic [7:0] HdrFirst  = 8'h06;
  localparam logic [7:0] HdrSecond = 8'h85;
  localparam logic [7:0] AckSecond = 8'h86;

  localparam logic [15:0] MaxLenReset = 16'd1024;

  // Phase codes of the frame parser.
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PhHunt1   = 3'd0;
  localparam logic [PhaseW-1:0] PhHunt2   = 3'd1;
  localparam logic [PhaseW-1:0] PhCode    = 3'd2;
  localparam logic [PhaseW-1:0] PhLenLo   = 3'd3;
  localparam logic [PhaseW-1:0] PhLenHi   = 3'd4;
  localparam logic [PhaseW-1:0] PhPayload = 3'd5;
  localparam logic [PhaseW-1:0] PhCsLo    = 3'd6;
  localparam logic [PhaseW-1:0] PhCsHi    = 3'd7;

  // Result queue between the parser and the output stage.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindAccept  = 2'd1,
    KindCsumErr = 2'd2,
    KindTooLong = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  code;
    logic [7:0]  data;
    logic [15:0] index;
  } res_t;

  typedef struct packed {
    logic push;
    res_t item;
  } push_t;

endpackage

/* rtl/fmr_if.sv */
// Valid/ready channel interfaces of the framed message receiver.
// Depends on nothing but the port widths given by the frame format.
interface fmr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fmr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  message_code;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;

  modport source (output valid, output result_kind, output message_code,
                  output payload_byte, output payload_index, input ready);
  modport sink (input valid, input result_kind, input message_code,
                input payload_byte, input payload_index, output ready);
endinterface

/* rtl/fmr_front.sv */
// Frame parser: accepts received bytes, runs the phase machine and pushes
// results into the queue. Depends on fmr_pkg and fmr_rx_if.
module fmr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         max_len_i,
  input  logic                full_i,
  fmr_rx_if.sink              rx_i,
  output fmr_pkg::push_t      push_o
);

  logic [fmr_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] len_q, len_d;
  logic [15:0] seen_q, seen_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  cslo_q, cslo_d;
  logic        accept;
  logic [7:0]  b;
  logic [15:0] full_len;

  assign rx_i.ready = !full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign full_len   = {b, len_q[7:0]};

  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    len_d   = len_q;
    seen_d  = seen_q;
    xor_d   = xor_q;
    cslo_d  = cslo_q;
    push_o.push       = 1'b0;
    push_o.item.kind  = fmr_pkg::KindPayload;
    push_o.item.code  = code_q;
    push_o.item.data  = 8'h00;
    push_o.item.index = len_q;
    if (accept) begin
      unique case (phase_q)
        fmr_pkg::PhHunt1: begin
          if (b == fmr_pkg::HdrFirst) phase_d = fmr_pkg::PhHunt2;
        end
        fmr_pkg::PhHunt2: begin
          phase_d = (b == fmr_pkg::HdrSecond) ? fmr_pkg::PhCode : fmr_pkg::PhHunt1;
        end
        fmr_pkg::PhCode: begin
          code_d  = b;
          phase_d = fmr_pkg::PhLenLo;
        end
        fmr_pkg::PhLenLo: begin
          len_d   = {8'h00, b};
          phase_d = fmr_pkg::PhLenHi;
        end
        fmr_pkg::PhLenHi: begin
          len_d  = full_len;
          seen_d = '0;
          xor_d  = '0;
          push_o.item.index = full_len;
          if (full_len == 16'd0) begin
            phase_d          = fmr_pkg::PhHunt1;
            push_o.push      = 1'b1;
            push_o.item.kind = fmr_pkg::KindAccept;
          end else if (full_len > max_len_i) begin
            phase_d          = fmr_pkg::PhHunt1;
            push_o.push      = 1'b1;
            push_o.item.kind = fmr_pkg::KindTooLong;
          end else begin
            phase_d = fmr_pkg::PhPayload;
          end
        end
        fmr_pkg::PhPayload: begin
          xor_d  = xor_q ^ b;
          seen_d = seen_q + 16'd1;
          if (seen_d == len_q) phase_d = fmr_pkg::PhCsLo;
          push_o.push       = 1'b1;
          push_o.item.kind  = fmr_pkg::KindPayload;
          push_o.item.data  = b;
          push_o.item.index = seen_q;
        end
        fmr_pkg::PhCsLo: begin
          cslo_d  = b;
          phase_d = fmr_pkg::PhCsHi;
        end
        fmr_pkg::PhCsHi: begin
          phase_d     = fmr_pkg::PhHunt1;
          push_o.push = 1'b1;
          push_o.item.kind = ((b == 8'h00) && (cslo_q == xor_q)) ?
                             fmr_pkg::KindAccept : fmr_pkg::KindCsumErr;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fmr_pkg::PhHunt1;
      code_q  <= '0;
      len_q   <= '0;
      seen_q  <= '0;
      xor_q   <= '0;
      cslo_q  <= '0;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      len_q   <= len_d;
      seen_q  <= seen_d;
      xor_q   <= xor_d;
      cslo_q  <= cslo_d;
    end
  end

endmodule

/* rtl/fmr_queue.sv */
// Short result queue that decouples the parser from the output stage.
// Depends on fmr_pkg.
module fmr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fmr_pkg::push_t push_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output fmr_pkg::res_t  head_o
);

  fmr_pkg::res_t mem_q [fmr_pkg::FifoDepth];
  logic [fmr_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [fmr_pkg::PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [fmr_pkg::CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == fmr_pkg::CntW'(fmr_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i.push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // The parser must never push into a full queue, nor the output stage pop an empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i.push |-> !full_o)
    else $error("fmr_queue: push while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("fmr_queue: pop while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= fmr_pkg::CntW'(fmr_pkg::FifoDepth))
    else $error("fmr_queue: count above depth");
  // The count and the pointers must agree whenever the queue is not full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !full_o |-> (fmr_pkg::PtrW'(count_q) == fmr_pkg::PtrW'(wr_ptr_q - rd_ptr_q)))
    else $error("fmr_queue: pointers disagree with count");

endmodule

/* rtl/fmr_back.sv */
// Output stage: pops results from the queue into a register that holds
// each transaction until the receiver takes it. Depends on fmr_pkg, fmr_res_if.
module fmr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  fmr_pkg::res_t head_i,
  output logic          pop_o,
  fmr_res_if.source     res_o
);

  fmr_pkg::res_t out_q;
  logic          valid_q, valid_d;

  assign pop_o   = !empty_i && (!valid_q || res_o.ready);
  assign valid_d = pop_o || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.result_kind   = out_q.kind;
  assign res_o.message_code  = out_q.code;
  assign res_o.payload_byte  = out_q.data;
  assign res_o.payload_index = out_q.index;

endmodule

/* rtl/framed_message_receiver.sv */
// Framed message receiver, top level: parser, result queue and output stage.
// Depends on fmr_pkg, fmr_if, fmr_front, fmr_queue and fmr_back.
//
// rx_i carries one received byte per transaction. The block hunts for the
// header 0x06 0x85, takes a message code and a little-endian length, passes
// each payload byte out as a result and closes the frame with an accepted,
// checksum error or length too large result; header and checksum bytes give
// no result. The host answers an accepted frame with the ACK 0x06 0x86.
// res_o carries the results in order. A byte is taken every cycle while the
// queue is not full; its result is registered in the queue, then in the output
// register that drives res_o, and held there until the receiver is ready.
// A four-entry queue plus the output register absorb stalls of the receiver;
// rx_i.ready drops only when the queue is full. cfg_we_i writes the largest
// accepted payload length (1024 after reset); write it while idle.
// Reset puts the parser in header hunt and empties the queue and output.
module framed_message_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  fmr_rx_if.sink      rx_i,
  fmr_res_if.source   res_o
);

  logic [15:0]    max_len_q;
  fmr_pkg::push_t push;
  fmr_pkg::res_t  head;
  logic           full;
  logic           empty;
  logic           pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= fmr_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  fmr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .max_len_i (max_len_q),
    .full_i    (full),
    .rx_i      (rx_i),
    .push_o    (push)
  );

  fmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  fmr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
